// ----- hw/rtl/erc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_pkg: shared types and constants for the relay card controller
// Command modes, reply kinds, sequencer states, settings register indices and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package erc_pkg;

  typedef enum logic [3:0] {
    MODE_ON       = 4'd0,
    MODE_OFF      = 4'd1,
    MODE_TOGGLE   = 4'd2,
    MODE_SETBTN   = 4'd3,
    MODE_QBTN     = 4'd4,
    MODE_START    = 4'd5,
    MODE_SETTIMER = 4'd6,
    MODE_QTIMER   = 4'd7,
    MODE_QRELAY   = 4'd8,
    MODE_FACTORY  = 4'd9,
    MODE_JUMPER   = 4'd10,
    MODE_FIRMWARE = 4'd11,
    MODE_TICK     = 4'd12
  } mode_t;

  typedef enum logic [2:0] {
    KIND_STATUS   = 3'd0,
    KIND_BUTTON   = 3'd1,
    KIND_TIMER    = 3'd2,
    KIND_JUMPER   = 3'd3,
    KIND_FIRMWARE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MD,
    ST_EM,
    ST_ROUND,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    REG_MERGE    = 2'd0,
    REG_JUMPER   = 2'd1,
    REG_FW_YEAR  = 2'd2,
    REG_FW_WEEK  = 2'd3
  } reg_idx_t;

  localparam int          RELAY_SLOTS  = 8;
  localparam int          ADDR_W       = 3;
  localparam int          SEC_W        = 16;
  localparam int          MS_W         = 26;
  localparam logic [15:0] DEF_SECONDS  = 16'd5;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
  localparam logic [25:0] ROUND_UP_MS  = 26'd999;
  // ceil(2^36 / 1000): exact quotient for all values below 2^26
  localparam logic [26:0] RECIP_1000   = 27'd68719477;
  localparam int          RECIP_SHIFT  = 36;
  localparam int          PROD_W       = 53;

endpackage

// ----- hw/rtl/erc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_if: command and reply channel interfaces
// Valid/ready channels carrying one command item or one reply item.
// ----------------------------------------------------------------------------
interface erc_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [7:0] relay_mask;
  logic [7:0] param_high;
  logic [7:0] param_low;

  modport source (output valid, mode, relay_mask, param_high, param_low, input ready);
  modport sink   (input valid, mode, relay_mask, param_high, param_low, output ready);
endinterface

interface erc_reply_if;
  logic       valid;
  logic       ready;
  logic [2:0] reply_kind;
  logic [7:0] reply_first;
  logic [7:0] reply_second;
  logic [7:0] reply_third;
  logic       reply_last;

  modport source (output valid, reply_kind, reply_first, reply_second, reply_third,
                  reply_last, input ready);
  modport sink   (input valid, reply_kind, reply_first, reply_second, reply_third,
                  reply_last, output ready);
endinterface

// ----- hw/rtl/erc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erc_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module erc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/eight_relay_card_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_relay_card_controller: command sequencer for an eight-relay card
// Relay, button and timer bits in flops; per-relay seconds and ms in RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command or one 1 ms tick per item; reply carries the
//   result items, reply_last set on the last one an item causes. The user
//   must use cfg_we/cfg_index/cfg_data to write the four settings only while
//   the block is idle; the block itself does not enforce this.
// Timing:
//   cmd.ready is high only in the idle state. Plain commands are accepted,
//   then finish. Start, query-timer and tick walk the eight relay slots
//   through the timer RAMs one slot at a time: an unselected slot is only
//   read; a selected slot is read, then modified/written, and for
//   query-timer its reply is emitted. Set-timer writes each selected slot
//   in its read state. Start and set-timer end in the finish state; a tick
//   ends with one expiry round per reply until no running relay is at zero.
// Reset:
//   Synchronous, active high. Defaults return at once through per-slot valid
//   bits on the seconds RAM; the ms RAM is only read for running timers.
// Stall:
//   Results go through a one-entry output register; a new item may be
//   accepted while it waits. The sequencer holds when it has a result to
//   give and the register is still full.
// ----------------------------------------------------------------------------
module eight_relay_card_controller #(
  parameter int RELAY_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  erc_cmd_if.sink     cmd,
  erc_reply_if.source reply,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam logic [7:0] RELAYS_MASK = 8'((9'd1 << RELAY_COUNT) - 9'd1);
  localparam logic [erc_pkg::ADDR_W-1:0] LAST_IDX = erc_pkg::ADDR_W'(RELAY_COUNT - 1);

  // settings
  logic [9:0] merge_window;
  logic [7:0] jumper_state;
  logic [7:0] fw_year;
  logic [7:0] fw_week;

  // latched command
  erc_pkg::mode_t mode;
  logic [7:0] mask;
  logic [7:0] hi;
  logic [7:0] lo;

  erc_pkg::state_t state, state_next;
  logic [erc_pkg::ADDR_W-1:0] idx;

  // bit state
  logic [7:0] relay_on, relay_on_next;
  logic [7:0] active, active_next;
  logic [7:0] mom, mom_next;
  logic [7:0] tog, tog_next;
  logic [7:0] timed, timed_next;
  logic [7:0] def_valid, def_valid_next;
  logic [7:0] zero_f;   // timer reached zero on this tick
  logic [7:0] below_f;  // timer below the merge window on this tick

  // query pipeline
  logic [erc_pkg::PROD_W-1:0] prod;
  logic [15:0] q_word;
  logic        q_use_prod;

  // output register
  logic       out_valid;
  logic [2:0] out_kind;
  logic [7:0] out_first, out_second, out_third;
  logic       out_last;
  logic       out_free;

  // RAMs
  logic                       def_we, rem_we;
  logic [erc_pkg::SEC_W-1:0]  def_wdata, def_rdata;
  logic [erc_pkg::MS_W-1:0]   rem_wdata, rem_rdata;

  erc_ram #(.WIDTH(erc_pkg::SEC_W), .DEPTH(erc_pkg::RELAY_SLOTS), .AW(erc_pkg::ADDR_W))
    u_def_ram (.clk(clk), .we(def_we), .addr(idx), .wdata(def_wdata), .rdata(def_rdata));

  erc_ram #(.WIDTH(erc_pkg::MS_W), .DEPTH(erc_pkg::RELAY_SLOTS), .AW(erc_pkg::ADDR_W))
    u_rem_ram (.clk(clk), .we(rem_we), .addr(idx), .wdata(rem_wdata), .rdata(rem_rdata));

  // helper terms
  logic        accept;
  logic        is_last;
  logic        sel_bit;
  logic [7:0]  above;
  logic [15:0] def_eff;
  logic [15:0] param_word;
  logic [15:0] start_sec;
  logic [25:0] dec_ms;
  logic [7:0]  cand, oh, rbits, r_act;
  erc_pkg::state_t after_sweep;

  // finish / emit terms
  logic       ld_out;
  logic [2:0] ld_kind;
  logic [7:0] ld_first, ld_second, ld_third;
  logic       ld_last;
  logic       fin_emit;

  assign out_free  = !out_valid || reply.ready;
  assign cmd.ready = (state == erc_pkg::ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign is_last   = (idx == LAST_IDX);
  assign sel_bit   = (mode == erc_pkg::MODE_TICK) ? active[idx] : mask[idx];
  assign above     = mask & ~((8'd2 << idx) - 8'd1);
  assign def_eff   = def_valid[idx] ? def_rdata : erc_pkg::DEF_SECONDS;
  assign param_word = {hi, lo};
  assign start_sec = (param_word != 16'd0) ? param_word : def_eff;
  assign dec_ms    = (rem_rdata != 26'd0) ? rem_rdata - 26'd1 : rem_rdata;
  assign cand      = active & zero_f;
  assign oh        = cand & (~cand + 8'd1);   // lowest relay first
  assign rbits     = oh | (active & below_f);
  assign r_act     = active & ~rbits;

  always_comb begin
    case (mode)
      erc_pkg::MODE_TICK:   after_sweep = erc_pkg::ST_ROUND;
      erc_pkg::MODE_QTIMER: after_sweep = erc_pkg::ST_IDLE;
      default:              after_sweep = erc_pkg::ST_FIN;
    endcase
  end

  // RAM access
  always_comb begin
    def_we    = (state == erc_pkg::ST_RD) && (mode == erc_pkg::MODE_SETTIMER) && sel_bit;
    def_wdata = param_word;
    rem_we    = (state == erc_pkg::ST_MD) &&
                ((mode == erc_pkg::MODE_START) || (mode == erc_pkg::MODE_TICK));
    if (mode == erc_pkg::MODE_START) begin
      rem_wdata = 26'(start_sec) * 26'(erc_pkg::MS_PER_SEC);
    end else begin
      rem_wdata = dec_ms;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      erc_pkg::ST_IDLE: begin
        if (accept) begin
          case (erc_pkg::mode_t'(cmd.mode))
            erc_pkg::MODE_START, erc_pkg::MODE_SETTIMER,
            erc_pkg::MODE_QTIMER, erc_pkg::MODE_TICK: state_next = erc_pkg::ST_RD;
            default:                                  state_next = erc_pkg::ST_FIN;
          endcase
        end
      end
      erc_pkg::ST_RD: begin
        if (sel_bit && (mode != erc_pkg::MODE_SETTIMER)) state_next = erc_pkg::ST_MD;
        else if (is_last)                                state_next = after_sweep;
      end
      erc_pkg::ST_MD: begin
        if (mode == erc_pkg::MODE_QTIMER) state_next = erc_pkg::ST_EM;
        else if (is_last)                 state_next = after_sweep;
        else                              state_next = erc_pkg::ST_RD;
      end
      erc_pkg::ST_EM: begin
        if (out_free) state_next = is_last ? erc_pkg::ST_IDLE : erc_pkg::ST_RD;
      end
      erc_pkg::ST_ROUND: begin
        if (cand == 8'd0) state_next = erc_pkg::ST_IDLE;
      end
      erc_pkg::ST_FIN: begin
        if (!fin_emit || out_free) state_next = erc_pkg::ST_IDLE;
      end
      default: state_next = erc_pkg::ST_IDLE;
    endcase
  end

  // outputs and bit-state updates
  always_comb begin
    relay_on_next  = relay_on;
    active_next    = active;
    mom_next       = mom;
    tog_next       = tog;
    timed_next     = timed;
    def_valid_next = def_valid;
    fin_emit       = 1'b0;
    ld_out         = 1'b0;
    ld_kind        = erc_pkg::KIND_STATUS;
    ld_first       = relay_on;
    ld_second      = relay_on;
    ld_third       = active;
    ld_last        = 1'b1;

    case (state)
      erc_pkg::ST_RD: begin
        if (def_we) def_valid_next = def_valid | (8'd1 << idx);
      end
      erc_pkg::ST_EM: begin
        ld_out    = out_free;
        ld_kind   = erc_pkg::KIND_TIMER;
        ld_first  = 8'd1 << idx;
        ld_second = q_use_prod ? prod[erc_pkg::RECIP_SHIFT+8 +: 8] : q_word[15:8];
        ld_third  = q_use_prod ? prod[erc_pkg::RECIP_SHIFT +: 8] : q_word[7:0];
        ld_last   = (above == 8'd0);
      end
      erc_pkg::ST_ROUND: begin
        if (cand != 8'd0 && out_free) begin
          ld_out        = 1'b1;
          ld_second     = relay_on & ~rbits;
          ld_third      = r_act;
          ld_last       = ((r_act & zero_f) == 8'd0);
          relay_on_next = relay_on & ~rbits;
          active_next   = r_act;
        end
      end
      erc_pkg::ST_FIN: begin
        case (mode)
          erc_pkg::MODE_ON, erc_pkg::MODE_START: begin
            fin_emit  = ((relay_on | mask) != relay_on);
            ld_second = relay_on | mask;
            ld_third  = (mode == erc_pkg::MODE_START) ? (active | mask) : active;
            if (out_free || !fin_emit) begin
              relay_on_next = relay_on | mask;
              active_next   = ld_third;
            end
          end
          erc_pkg::MODE_OFF: begin
            fin_emit  = ((relay_on & ~mask) != relay_on);
            ld_second = relay_on & ~mask;
            ld_third  = fin_emit ? (active & ~mask) : active;
            if (out_free || !fin_emit) begin
              relay_on_next = ld_second;
              active_next   = ld_third;
            end
          end
          erc_pkg::MODE_TOGGLE: begin
            fin_emit  = (mask != 8'd0);
            ld_second = relay_on ^ mask;
            ld_third  = active & ~(relay_on & mask);
            if (out_free || !fin_emit) begin
              relay_on_next = ld_second;
              active_next   = ld_third;
            end
          end
          erc_pkg::MODE_SETBTN: begin
            mom_next   = mask;
            tog_next   = hi & ~mask & RELAYS_MASK;
            timed_next = lo & ~(mask | (hi & ~mask)) & RELAYS_MASK;
          end
          erc_pkg::MODE_QBTN: begin
            fin_emit  = 1'b1;
            ld_kind   = erc_pkg::KIND_BUTTON;
            ld_first  = mom;
            ld_second = tog;
            ld_third  = timed;
          end
          erc_pkg::MODE_QRELAY: begin
            fin_emit = 1'b1;
          end
          erc_pkg::MODE_FACTORY: begin
            fin_emit  = (relay_on != 8'd0);
            ld_second = 8'd0;
            ld_third  = active & ~relay_on;
            if (out_free || !fin_emit) begin
              mom_next       = 8'd0;
              tog_next       = RELAYS_MASK;
              timed_next     = 8'd0;
              def_valid_next = 8'd0;
              relay_on_next  = 8'd0;
              active_next    = ld_third;
            end
          end
          erc_pkg::MODE_JUMPER: begin
            fin_emit  = 1'b1;
            ld_kind   = erc_pkg::KIND_JUMPER;
            ld_first  = 8'd0;
            ld_second = jumper_state;
            ld_third  = 8'd0;
          end
          erc_pkg::MODE_FIRMWARE: begin
            fin_emit  = 1'b1;
            ld_kind   = erc_pkg::KIND_FIRMWARE;
            ld_first  = 8'd0;
            ld_second = fw_year;
            ld_third  = fw_week;
          end
          default: fin_emit = 1'b0;   // set-timer and unused modes
        endcase
        ld_out = fin_emit && out_free;
      end
      default: ld_out = 1'b0;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= erc_pkg::ST_IDLE;
      idx          <= '0;
      relay_on     <= 8'd0;
      active       <= 8'd0;
      mom          <= 8'd0;
      tog          <= RELAYS_MASK;
      timed        <= 8'd0;
      def_valid    <= 8'd0;
      zero_f       <= 8'd0;
      below_f      <= 8'd0;
      out_valid    <= 1'b0;
      merge_window <= 10'd100;
      jumper_state <= 8'd0;
      fw_year      <= 8'd16;
      fw_week      <= 8'd6;
    end else begin
      state     <= state_next;
      relay_on  <= relay_on_next;
      active    <= active_next;
      mom       <= mom_next;
      tog       <= tog_next;
      timed     <= timed_next;
      def_valid <= def_valid_next;

      if (cfg_we) begin
        case (erc_pkg::reg_idx_t'(cfg_index))
          erc_pkg::REG_MERGE:   merge_window <= cfg_data;
          erc_pkg::REG_JUMPER:  jumper_state <= cfg_data[7:0];
          erc_pkg::REG_FW_YEAR: fw_year      <= cfg_data[7:0];
          erc_pkg::REG_FW_WEEK: fw_week      <= cfg_data[7:0];
          default: ;
        endcase
      end

      // slot index walk
      if (accept) begin
        idx <= '0;
      end else if (!is_last) begin
        case (state)
          erc_pkg::ST_RD:
            if (!(sel_bit && (mode != erc_pkg::MODE_SETTIMER))) idx <= idx + 1'b1;
          erc_pkg::ST_MD:
            if (mode != erc_pkg::MODE_QTIMER) idx <= idx + 1'b1;
          erc_pkg::ST_EM:
            if (out_free) idx <= idx + 1'b1;
          default: ;
        endcase
      end

      if (accept) begin
        zero_f  <= 8'd0;
        below_f <= 8'd0;
      end else if (state == erc_pkg::ST_MD && mode == erc_pkg::MODE_TICK) begin
        zero_f[idx]  <= (dec_ms == 26'd0);
        below_f[idx] <= (dec_ms < 26'(merge_window));
      end

      if (ld_out)        out_valid <= 1'b1;
      else if (reply.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= erc_pkg::mode_t'(cmd.mode);
      mask <= cmd.relay_mask & RELAYS_MASK;
      hi   <= cmd.param_high;
      lo   <= cmd.param_low;
    end
    if (state == erc_pkg::ST_MD) begin
      // remaining seconds rounded up: (ms + 999) / 1000 by reciprocal
      prod       <= erc_pkg::PROD_W'(rem_rdata + erc_pkg::ROUND_UP_MS) *
                    erc_pkg::PROD_W'(erc_pkg::RECIP_1000);
      q_use_prod <= (hi != 8'd0) && active[idx];
      q_word     <= (hi == 8'd0) ? def_eff : 16'd0;
    end
    if (ld_out) begin
      out_kind   <= ld_kind;
      out_first  <= ld_first;
      out_second <= ld_second;
      out_third  <= ld_third;
      out_last   <= ld_last;
    end
  end

  assign reply.valid        = out_valid;
  assign reply.reply_kind   = out_kind;
  assign reply.reply_first  = out_first;
  assign reply.reply_second = out_second;
  assign reply.reply_third  = out_third;
  assign reply.reply_last   = out_last;

endmodule
